@@ hdl/packet_id_history_ring_core_defines.svh @@
// Assertion macros shared by the packet ID history ring.
`ifndef PACKET_ID_HISTORY_RING_CORE_DEFINES_SVH
`define PACKET_ID_HISTORY_RING_CORE_DEFINES_SVH

// Plain property checked at every clock edge outside reset.
`define PKH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property whose consequent is checked in the cycle after the antecedent.
`define PKH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/pkh_pkg.sv @@
package pkh_pkg;

  localparam int unsigned CmdW = 3;
  localparam int unsigned IdW  = 16;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_SEARCH = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT,
    CELL_WRITE_TAIL,
    CELL_REMOVE
  } cell_op_e;

  typedef struct packed {
    logic     capture;
    cell_op_e op;
  } cell_ctrl_t;

endpackage

@@ hdl/pkh_cell.sv @@
module pkh_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pkh_pkg::cell_ctrl_t    ctrl_i,
  input  logic [CNT_W-1:0]       count_i,
  input  logic [pkh_pkg::IdW-1:0] probe_id_i,
  input  logic [pkh_pkg::IdW-1:0] wdata_i,
  input  logic [pkh_pkg::IdW-1:0] next_data_i,
  input  logic                   found_i,
  output logic [pkh_pkg::IdW-1:0] data_o,
  output logic                   found_o
);
  import pkh_pkg::*;

  localparam logic [CNT_W-1:0] MyIdx = CNT_W'(IDX);

  logic [IdW-1:0] data_q;
  logic [IdW-1:0] data_d;
  logic           hit_q;
  logic           held;

  assign held    = MyIdx < count_i;
  // Found ripples toward the newest cell, so every cell at or past the
  // oldest match sees it.
  assign found_o = found_i | hit_q;
  assign data_o  = data_q;

  always_comb begin
    data_d = data_q;
    unique case (ctrl_i.op)
      CELL_HOLD:       data_d = data_q;
      CELL_SHIFT:      data_d = next_data_i;
      CELL_WRITE_TAIL: if (MyIdx == count_i) data_d = wdata_i;
      CELL_REMOVE:     if (found_o) data_d = next_data_i;
      default:         data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (ctrl_i.capture) begin
      hit_q <= held && (data_q == probe_id_i);
    end
  end

endmodule

@@ hdl/packet_id_history_ring_core.sv @@
// Packet ID history ring for duplicate detection.
// A command is taken at a rising edge where start is high and busy is low:
// cmd_i selects push, pop, search, remove or clear, packet_id_i carries the ID.
// Entries sit in a row of cells in age order, the oldest in the first cell.
// The edge that takes a command also latches an ID compare in every cell; the
// next edge applies the command, with pop and full push shifting the whole row
// and remove shifting the cells at and beyond the oldest match by one place.
// One result per command: result_valid_o is high for exactly one cycle, the
// cycle right after the apply edge, with ok_o, popped_id_o and fill_count_o.
// The receiver cannot stall; the strobe is not repeated.
// busy is high for one cycle after each acceptance, so no new command is
// taken while one is being applied; the next is taken in the same cycle as
// the previous result.
// The found flag ripples through the row of HISTORY_DEPTH cells, which sets
// the length of the apply path.
// Reset empties the ring and clears the strobe; stored IDs are not cleared
// since only held entries are ever read.
module packet_id_history_ring_core #(
  parameter int unsigned HISTORY_DEPTH = 16,
  localparam int unsigned CntW = $clog2(HISTORY_DEPTH + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [pkh_pkg::CmdW-1:0]    cmd_i,
  input  logic [pkh_pkg::IdW-1:0]     packet_id_i,
  output logic                        result_valid_o,
  output logic                        ok_o,
  output logic [pkh_pkg::IdW-1:0]     popped_id_o,
  output logic [CntW-1:0]             fill_count_o
);
  import pkh_pkg::*;
  `include "packet_id_history_ring_core_defines.svh"

  localparam logic [CntW-1:0] Full = CntW'(HISTORY_DEPTH);

  typedef enum logic {ST_IDLE, ST_APPLY} state_e;

  state_e          state_q;
  logic [CmdW-1:0] cmd_q;
  logic [IdW-1:0]  id_q;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_d;
  logic            accept;
  logic            found;
  logic            ok_d;
  logic [IdW-1:0]  popped_d;
  cell_ctrl_t      ctrl;

  logic [IdW-1:0]  cell_data  [HISTORY_DEPTH+1];
  logic            cell_found [HISTORY_DEPTH+1];

  assign accept = start && !busy;
  assign busy   = (state_q == ST_APPLY);

  assign cell_data[HISTORY_DEPTH] = id_q;
  assign cell_found[0]            = 1'b0;
  assign found                    = cell_found[HISTORY_DEPTH];

  for (genvar k = 0; k < HISTORY_DEPTH; k++) begin : g_cell
    pkh_cell #(
      .IDX   (k),
      .CNT_W (CntW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .count_i     (count_q),
      .probe_id_i  (packet_id_i),
      .wdata_i     (id_q),
      .next_data_i (cell_data[k+1]),
      .found_i     (cell_found[k]),
      .data_o      (cell_data[k]),
      .found_o     (cell_found[k+1])
    );
  end

  always_comb begin
    ctrl.capture = accept;
    ctrl.op      = CELL_HOLD;
    count_d      = count_q;
    ok_d         = 1'b0;
    popped_d     = '0;
    if (state_q == ST_APPLY) begin
      unique case (cmd_e'(cmd_q))
        CMD_PUSH: begin
          ok_d = 1'b1;
          if (count_q == Full) begin
            ctrl.op = CELL_SHIFT;
          end else begin
            ctrl.op = CELL_WRITE_TAIL;
            count_d = count_q + CntW'(1);
          end
        end
        CMD_POP: begin
          if (count_q != '0) begin
            ctrl.op  = CELL_SHIFT;
            count_d  = count_q - CntW'(1);
            ok_d     = 1'b1;
            popped_d = cell_data[0];
          end
        end
        CMD_SEARCH: ok_d = found;
        CMD_REMOVE: begin
          ok_d = found;
          if (found) begin
            ctrl.op = CELL_REMOVE;
            count_d = count_q - CntW'(1);
          end
        end
        CMD_CLEAR: begin
          ok_d    = 1'b1;
          count_d = '0;
        end
        default: ok_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
      id_q  <= packet_id_i;
    end
    ok_o         <= ok_d;
    popped_id_o  <= popped_d;
    fill_count_o <= count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      count_q        <= '0;
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= (state_q == ST_APPLY);
      count_q        <= count_d;
      unique case (state_q)
        ST_IDLE:  if (accept) state_q <= ST_APPLY;
        ST_APPLY: state_q <= ST_IDLE;
        default:  state_q <= ST_IDLE;
      endcase
    end
  end

  `PKH_ASSERT(a_count_bound, count_q <= Full, "fill count beyond ring depth")
  `PKH_ASSERT_NEXT(a_one_result, start && !busy,
                   (busy && !result_valid_o) ##1 (result_valid_o && !busy),
                   "no result after command")
  `PKH_ASSERT_NEXT(a_count_step, state_q == ST_APPLY && cmd_q != CMD_CLEAR,
                   (count_q == $past(count_q)) ||
                   (count_q == $past(count_q) + CntW'(1)) ||
                   (count_q == $past(count_q) - CntW'(1)),
                   "fill count jumped")
  `PKH_ASSERT(a_result_count, result_valid_o |-> fill_count_o == count_q,
              "reported count differs from held count")

endmodule

@@ sim/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pkh_pkg::*;

  localparam int unsigned RingDepth  = 16;
  localparam int unsigned FillW      = $clog2(RingDepth + 1);
  localparam int unsigned CycleLimit = 100000;
  localparam int unsigned CmdMax     = (1 << CmdW) - 1;

  typedef struct packed {
    bit            ok;
    bit [IdW-1:0]  popped_id;
    bit [FillW-1:0] fill_count;
  } ring_outcome_t;

  typedef enum {FILL_UP, DRAIN, MIXED} burst_mix_e;

  // Tracks the held IDs in age order, oldest first, and the outcomes still owed.
  class id_history_board;
    bit [IdW-1:0]  held_ids[$];
    ring_outcome_t owed_outcomes[$];
    int unsigned   mismatches;

    function void note_command(logic [CmdW-1:0] cmd, logic [IdW-1:0] id);
      ring_outcome_t o;
      int            hit;
      o   = '0;
      hit = -1;
      for (int k = 0; k < held_ids.size() && hit < 0; k++) begin
        if (held_ids[k] == id) hit = k;
      end
      case (cmd)
        CMD_PUSH: begin
          if (held_ids.size() == RingDepth) held_ids.delete(0);
          held_ids.push_back(id);
          o.ok = 1'b1;
        end
        CMD_POP: begin
          if (held_ids.size() != 0) begin
            o.popped_id = held_ids[0];
            held_ids.delete(0);
            o.ok = 1'b1;
          end
        end
        CMD_SEARCH: o.ok = (hit >= 0);
        CMD_REMOVE: begin
          if (hit >= 0) begin
            held_ids.delete(hit);
            o.ok = 1'b1;
          end
        end
        CMD_CLEAR: begin
          held_ids.delete();
          o.ok = 1'b1;
        end
        default: ;
      endcase
      o.fill_count = FillW'(held_ids.size());
      owed_outcomes.push_back(o);
    endfunction

    function void check_result(logic ok, logic [IdW-1:0] popped_id,
                               logic [FillW-1:0] fill_count);
      ring_outcome_t o;
      if (owed_outcomes.size() == 0) begin
        $display("%0t: result with none expected: ok %0b popped %h fill %0d",
                 $time, ok, popped_id, fill_count);
        mismatches++;
        return;
      end
      o = owed_outcomes.pop_front();
      if (ok !== o.ok) begin
        $display("%0t: ok expected %0b actual %0b", $time, o.ok, ok);
        mismatches++;
      end
      if (popped_id !== o.popped_id) begin
        $display("%0t: popped_id expected %h actual %h", $time, o.popped_id, popped_id);
        mismatches++;
      end
      if (fill_count !== o.fill_count) begin
        $display("%0t: fill_count expected %0d actual %0d", $time, o.fill_count,
                 fill_count);
        mismatches++;
      end
    endfunction
  endclass

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start       = 1'b0;
  logic [CmdW-1:0]  cmd_i       = CMD_PUSH;
  logic [IdW-1:0]   packet_id_i = '0;
  logic             busy;
  logic             result_valid_o;
  logic             ok_o;
  logic [IdW-1:0]   popped_id_o;
  logic [FillW-1:0] fill_count_o;

  int unsigned     cycle_count = 0;
  id_history_board board;

  packet_id_history_ring_core #(
    .HISTORY_DEPTH(RingDepth)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .packet_id_i   (packet_id_i),
    .result_valid_o(result_valid_o),
    .ok_o          (ok_o),
    .popped_id_o   (popped_id_o),
    .fill_count_o  (fill_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o === 1'b1) begin
      board.check_result(ok_o, popped_id_o, fill_count_o);
    end
  end

  // Called on a rising edge; returns on the edge that takes the item.
  task automatic issue(logic [CmdW-1:0] cmd, logic [IdW-1:0] id);
    start       <= 1'b1;
    cmd_i       <= cmd;
    packet_id_i <= id;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    board.note_command(cmd, id);
  endtask

  task automatic wait_until_settled();
    start <= 1'b0;
    @(posedge clk_i);
    while (board.owed_outcomes.size() != 0) @(posedge clk_i);
  endtask

  // Mostly IDs already held or a tiny pool, so that searches and removes hit
  // and duplicates pile up in the ring.
  function automatic logic [IdW-1:0] pick_id();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4 && board.held_ids.size() != 0) begin
      return board.held_ids[$urandom_range(0, board.held_ids.size() - 1)];
    end
    if (r < 7) return IdW'($urandom_range(0, 3));
    return IdW'($urandom);
  endfunction

  function automatic logic [CmdW-1:0] pick_cmd(burst_mix_e mix);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return CmdW'($urandom_range(CMD_CLEAR + 1, CmdMax));
    if (r < 5) return CMD_CLEAR;
    case (mix)
      FILL_UP: begin
        if (r < 70) return CMD_PUSH;
        if (r < 85) return CMD_SEARCH;
        return (r < 93) ? CMD_REMOVE : CMD_POP;
      end
      DRAIN: begin
        if (r < 25) return CMD_PUSH;
        if (r < 55) return CMD_POP;
        return (r < 85) ? CMD_REMOVE : CMD_SEARCH;
      end
      default: begin
        if (r < 45) return CMD_PUSH;
        if (r < 60) return CMD_POP;
        return (r < 80) ? CMD_SEARCH : CMD_REMOVE;
      end
    endcase
  endfunction

  initial begin
    burst_mix_e  mix;
    int unsigned sent;
    int unsigned burst_len;

    board = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty ring, then extremes of the ID, a full ring with a duplicate inside,
    // overflow, removal of the oldest match, unused codes and a clear.
    issue(CMD_POP, 16'h0000);
    issue(CMD_REMOVE, 16'h0000);
    issue(CMD_PUSH, 16'h0000);
    issue(CMD_PUSH, 16'hFFFF);
    issue(CMD_SEARCH, 16'hFFFF);
    issue(CMD_REMOVE, 16'h1234);
    for (int k = 0; k < RingDepth - 2; k++) begin
      issue(CMD_PUSH, (k == 5) ? 16'hFFFF : IdW'(16'h0100 + k));
    end
    issue(CMD_PUSH, 16'hBEEF);
    issue(CMD_SEARCH, 16'h0000);
    issue(CMD_REMOVE, 16'hFFFF);
    issue(CMD_POP, 16'hA5A5);
    issue(CmdW'(CMD_CLEAR + 1), 16'h5A5A);
    issue(CmdW'(CmdMax), 16'hFFFF);
    issue(CMD_CLEAR, 16'hFFFF);
    issue(CMD_POP, 16'h0000);
    wait_until_settled();

    for (int phase = 0; phase < 15; phase++) begin
      mix  = burst_mix_e'($urandom_range(0, 2));
      sent = 0;
      while (sent < 28) begin
        burst_len = $urandom_range(1, 12);
        for (int b = 0; b < burst_len && sent < 28; b++) begin
          issue(pick_cmd(mix), pick_id());
          sent++;
        end
        if ($urandom_range(0, 3) != 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 7)) @(posedge clk_i);
        end
      end
      if (phase % 4 == 1) wait_until_settled();
    end

    wait_until_settled();
    repeat (4) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/pkh_pkg.sv
hdl/pkh_cell.sv
hdl/packet_id_history_ring_core.sv
sim/tb.sv
